/* hw/rtl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue: command and status
// codes, item structs and default sizes.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DQ_CAPACITY   = 16;
  localparam int DQ_DATA_WIDTH = 32;

  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 4;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } stat_t;

  typedef struct packed {
    cmd_t                 command;
    logic [VALUE_W-1:0]   value;
    logic [INDEX_W-1:0]   index;
  } dq_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     read_value;
    stat_t                  status;
    logic [COUNT_OUT_W-1:0] count;
  } dq_out_t;

  // Result of one command, before the store data comes back
  typedef struct packed {
    logic                   rd;
    stat_t                  status;
    logic [COUNT_OUT_W-1:0] count;
  } dq_res_t;

endpackage

/* hw/rtl/dq_ring_mem.sv */
// ----------------------------------------------------------------------------
// dq_ring_mem
// Single-port ring store with a registered read: one write or one read per
// cycle, read data valid the cycle after the read.
// ----------------------------------------------------------------------------
module dq_ring_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Head pointer and element count. Decodes one command, issues the store
// access and produces status and new count.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; #(
  parameter int CAPACITY   = DQ_CAPACITY,
  parameter int DATA_WIDTH = DQ_DATA_WIDTH,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  dq_in_t                cmd_in,
  output dq_res_t               res,
  output logic                  mem_we,
  output logic                  mem_re,
  output logic [PW-1:0]         mem_addr,
  output logic [DATA_WIDTH-1:0] mem_wdata
);

  localparam int SW   = PW + 1;
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty, idx_oob;
  logic          wr, rd;
  stat_t         status;
  logic [SW-1:0] back_sum, back_wrap, idx_sum, idx_wrap;
  logic [PW-1:0] head_dec, head_inc;

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign idx_oob = (CMPW'(cmd_in.index) >= CMPW'(count_r));

  // Ring positions: back slot, indexed slot, and head moved either way
  assign back_sum  = SW'(head_r) + SW'(count_r);
  assign back_wrap = (back_sum >= SW'(CAPACITY)) ? back_sum - SW'(CAPACITY) : back_sum;
  assign idx_sum   = SW'(head_r) + SW'(cmd_in.index);
  assign idx_wrap  = (idx_sum >= SW'(CAPACITY)) ? idx_sum - SW'(CAPACITY) : idx_sum;
  assign head_dec  = (head_r == '0) ? PW'(CAPACITY - 1) : head_r - PW'(1);
  assign head_inc  = (head_r == PW'(CAPACITY - 1)) ? '0 : head_r + PW'(1);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = ST_OK;
    wr        = 1'b0;
    rd        = 1'b0;
    mem_addr  = head_r;
    unique case (cmd_in.command)
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          wr        = 1'b1;
          mem_addr  = back_wrap[PW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          wr        = 1'b1;
          mem_addr  = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_READ: begin
        if (idx_oob) begin
          status = ST_RANGE;
        end else begin
          rd       = 1'b1;
          mem_addr = idx_wrap[PW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we     = take && wr;
  assign mem_re     = take && rd;
  assign mem_wdata  = DATA_WIDTH'(cmd_in.value);
  assign res.rd     = rd;
  assign res.status = status;
  assign res.count  = COUNT_OUT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (take) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= PW'(CAPACITY - 1))
    else $error("head pointer outside ring");

  a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    take && (status != ST_OK) |=> (count_r == $past(count_r)) && (head_r == $past(head_r)))
    else $error("failed command changed queue state");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store written and read in one cycle");

endmodule

/* hw/rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity double-ended queue held in a ring store: push and pop at
// either end, read by position from the front, one result per command.
//
//   channel | ports                      | dir | payload
//   --------+----------------------------+-----+------------------------------
//   in      | in_valid in_stall in_data  | in  | command, value, index
//   out     | out_valid out_stall out_data| out | read_value, status, count
//
// One item per cycle unless a held result stalls the input side; its result
// appears in the output register in the cycle after acceptance, read data
// straight from the store's registered port. The next item is accepted while
// a result is being taken. Reset clears head, count and output valid; store
// entries are undefined until pushed and are never cleared.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
  parameter int CAPACITY   = DQ_CAPACITY,
  parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dq_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output dq_out_t out_data
);

  localparam int PW = $clog2(CAPACITY);

  logic                  take;
  dq_res_t               res;
  dq_res_t               res_r;
  logic                  out_valid_r;
  logic                  mem_we, mem_re;
  logic [PW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // Stall only while a result is held and not taken
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  dq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .cmd_in    (in_data),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  dq_ring_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  // Store read data holds until the next accepted read
  assign out_valid           = out_valid_r;
  assign out_data.read_value = res_r.rd ? VALUE_W'(mem_rdata) : '0;
  assign out_data.status     = res_r.status;
  assign out_data.count      = res_r.count;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue. A directed table runs the empty
// and full edges, wrap of the head pointer and out-of-range reads. Random
// traffic follows that swings the queue between empty and full. Each command
// goes through an in-bench deque predictor. Results are checked in order
// against it while both channels idle and stall at several rates.
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int ITEMS_PER_PASS = 275;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    dq_in_t  item;
    logic [4:0] repeats;
    logic       typed;
    dq_out_t    result;
  } stim_row_t;

  // Rows with typed = 1 carry their expected result; the rest are predicted.
  // Repeated rows bump the pushed value by the repetition number.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{'{CMD_POP_BACK,   32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{'{CMD_POP_FRONT,  32'hFFFF_FFFF, 4'd15}, 5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{'{CMD_READ,       32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
    '{'{CMD_READ,       32'h0000_0000, 4'd15}, 5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
    '{'{CMD_PUSH_BACK,  32'hFFFF_FFFF, 4'd15}, 5'd1,  1'b1, '{32'h0, ST_OK,    5'd1}},
    '{'{CMD_READ,       32'h0000_0000, 4'd0},  5'd1,  1'b1,
      '{32'hFFFF_FFFF, ST_OK, 5'd1}},
    '{'{CMD_PUSH_FRONT, 32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_OK,    5'd2}},
    '{'{CMD_READ,       32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_OK,    5'd2}},
    '{'{CMD_READ,       32'h0000_0000, 4'd1},  5'd1,  1'b1,
      '{32'hFFFF_FFFF, ST_OK, 5'd2}},
    '{'{CMD_READ,       32'h0000_0000, 4'd2},  5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd2}},
    '{'{CMD_PUSH_BACK,  32'hA5A5_5A5A, 4'd0},  5'd7,  1'b0, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_PUSH_FRONT, 32'h1234_5678, 4'd0},  5'd7,  1'b0, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_PUSH_BACK,  32'hDEAD_BEEF, 4'd0},  5'd1,  1'b1, '{32'h0, ST_FULL,  5'd16}},
    '{'{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0},  5'd1,  1'b1, '{32'h0, ST_FULL,  5'd16}},
    '{'{CMD_READ,       32'h0000_0000, 4'd15}, 5'd1,  1'b0, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_READ,       32'h0000_0000, 4'd0},  5'd1,  1'b0, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_POP_BACK,   32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_OK,    5'd15}},
    '{'{CMD_POP_FRONT,  32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_OK,    5'd14}},
    '{'{CMD_READ,       32'h0000_0000, 4'd14}, 5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd14}},
    '{'{CMD_READ,       32'h0000_0000, 4'd13}, 5'd1,  1'b0, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_POP_FRONT,  32'h0000_0000, 4'd0},  5'd13, 1'b0, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_POP_BACK,   32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_OK,    5'd0}},
    '{'{CMD_POP_BACK,   32'h0000_0000, 4'd0},  5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{'{CMD_PUSH_FRONT, 32'h8000_0001, 4'd0},  5'd1,  1'b1, '{32'h0, ST_OK,    5'd1}},
    '{'{CMD_READ,       32'h0000_0000, 4'd0},  5'd1,  1'b1,
      '{32'h8000_0001, ST_OK, 5'd1}}
  };

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  dq_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  dq_out_t out_data;

  // predicted deque contents
  logic [DQ_DATA_WIDTH-1:0] slots [DQ_CAPACITY];
  logic [INDEX_W-1:0]       front_ptr = '0;
  logic [COUNT_OUT_W-1:0]   occupancy = '0;

  dq_out_t pending_results [$];
  int      mismatches     = 0;
  int      results_seen   = 0;
  int      cycle_count    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;

  double_ended_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one command to the predicted deque and return its result.
  function automatic dq_out_t apply_command(input dq_in_t item);
    dq_out_t            res;
    logic [INDEX_W-1:0] slot;
    res = '0;
    res.status = ST_OK;
    case (item.command)
      CMD_PUSH_BACK: begin
        if (occupancy == COUNT_OUT_W'(DQ_CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          slot = front_ptr + occupancy[INDEX_W-1:0];
          slots[slot] = item.value;
          occupancy = occupancy + COUNT_OUT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (occupancy == COUNT_OUT_W'(DQ_CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          front_ptr = front_ptr - INDEX_W'(1);
          slots[front_ptr] = item.value;
          occupancy = occupancy + COUNT_OUT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (occupancy == '0) res.status = ST_EMPTY;
        else occupancy = occupancy - COUNT_OUT_W'(1);
      end
      CMD_POP_FRONT: begin
        if (occupancy == '0) begin
          res.status = ST_EMPTY;
        end else begin
          front_ptr = front_ptr + INDEX_W'(1);
          occupancy = occupancy - COUNT_OUT_W'(1);
        end
      end
      CMD_READ: begin
        if (COUNT_OUT_W'(item.index) >= occupancy) begin
          res.status = ST_RANGE;
        end else begin
          slot = front_ptr + item.index;
          res.read_value = slots[slot];
        end
      end
      default: begin
      end
    endcase
    res.count = occupancy;
    return res;
  endfunction

  // Drive one item, wait for its acceptance, then queue what it must return.
  task automatic issue(input dq_in_t item, input logic typed, input dq_out_t typed_result);
    dq_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = apply_command(item);
    pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
  endtask

  // Random command, biased toward pushes or pops by push_pct.
  function automatic dq_in_t random_command(input int push_pct);
    dq_in_t item;
    int     pick;
    pick = $urandom_range(0, 99);
    item.value = $urandom;
    if ($urandom_range(0, 7) == 0) item.value = $urandom_range(0, 1) ? '1 : '0;
    item.index = INDEX_W'($urandom_range(0, 15));
    if (pick < 25) begin
      item.command = CMD_READ;
      if (occupancy != '0 && $urandom_range(0, 3) != 0)
        item.index = INDEX_W'($urandom_range(0, int'(occupancy) - 1));
    end else if (pick < 25 + push_pct * 75 / 100) begin
      item.command = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else begin
      item.command = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    end
    return item;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    dq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, read_value", out_data.read_value, '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.count !== want.count)
          report_mismatch("count", 32'(out_data.count), 32'(want.count));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dq_in_t item;
    int     push_pct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[r]) begin
      for (int k = 0; k < int'(DIRECTED_ROWS[r].repeats); k++) begin
        item = DIRECTED_ROWS[r].item;
        item.value = item.value + 32'(k);
        issue(item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
      end
    end

    // no idling, sender idle, receiver stalling, both
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      push_pct = 50;
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        // swing between filling, draining and balanced traffic
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
          endcase
        end
        issue(random_command(push_pct), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/dq_pkg.sv
hw/rtl/dq_ring_mem.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue.sv
sim/testbench.sv
